// ----- sv/vgt_pkg.sv -----
// Package: shared types, constants and register map of the gossip table.
`timescale 1ns / 1ps
package vgt_pkg;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned RecW = 25;  // {state, version, id}
  localparam logic [7:0] FloodMark = 8'hF1;
  localparam logic [7:0] ThreshReset = 8'd10;
  localparam logic [7:0] DetectReset = 8'd100;

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpRecv  = 2'd1;
  localparam logic [1:0] OpBuild = 2'd2;
  localparam logic [1:0] OpSent  = 2'd3;

  localparam logic [1:0] RegOwnUid = 2'd0;
  localparam logic [1:0] RegThresh = 2'd1;
  localparam logic [1:0] RegDetect = 2'd2;

  // scan targets of the sequencer
  localparam logic [1:0] TgtSelf     = 2'd0;  // own record after a vote
  localparam logic [1:0] TgtFirst    = 2'd1;
  localparam logic [1:0] TgtSecond   = 2'd2;
  localparam logic [1:0] TgtSelfPost = 2'd3;  // own record after a merge

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  opinion_byte;
    logic [7:0]  header_byte;
    logic [7:0]  marker_byte;
    logic [15:0] first_uid;
    logic [7:0]  first_version;
    logic [15:0] second_uid;
    logic [7:0]  second_version;
  } item_t;

  typedef struct packed {
    logic        out_opinion;
    logic [3:0]  out_header;
    logic [15:0] out_first_uid;
    logic [7:0]  out_first_version;
    logic [15:0] out_second_uid;
    logic [7:0]  out_second_version;
    logic        local_complete;
    logic        meta_complete;
    logic [7:0]  known_count;
  } result_t;

  typedef struct packed {
    logic [15:0] own_uid;
    logic [7:0]  agree_limit;
    logic [7:0]  detection_count;
  } cfg_t;
endpackage

// ----- sv/vgt_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vgt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/vgt_regs.sv -----
// APB configuration registers.
`timescale 1ns / 1ps
module vgt_regs import vgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_uid: 16'd0, agree_limit: ThreshReset, detection_count: DetectReset};
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegOwnUid: cfg_q.own_uid <= pwdata[15:0];
        RegThresh: cfg_q.agree_limit <= pwdata[7:0];
        RegDetect: cfg_q.detection_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (idx)
        RegOwnUid: prdata = {16'd0, cfg_q.own_uid};
        RegThresh: prdata = {24'd0, cfg_q.agree_limit};
        RegDetect: prdata = {24'd0, cfg_q.detection_count};
        default:   prdata = '0;
      endcase
    end
  end
endmodule

// ----- sv/vgt_seq.sv -----
// Sequencer: table scans, merges, voting and payload build over one RAM port.
`timescale 1ns / 1ps
module vgt_seq import vgt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_VOTE, S_SCAN, S_SCAN_WAIT, S_SCAN_CHK, S_UPD, S_NEXT,
    S_GCHK, S_GWAIT, S_GTEST, S_B1, S_B1W, S_B2W, S_OUT
  } state_e;

  state_e      state_q;
  item_t       it_q;
  logic [CntW-1:0] total_q, idx_q;
  logic [7:0]  self_ver_q, agree_q;
  logic        opin_q, dl_q, dg_q;
  logic [IdxW-1:0] cur_q;
  logic [1:0]  sent_q, tgt_q;
  logic        merge_q;
  result_t     res_q;
  logic        rv_q;

  logic            we;
  logic [IdxW-1:0] addr;
  logic [RecW-1:0] wdata, rdata;

  vgt_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [15:0] key;
  logic        kst;
  logic [7:0]  kver, diff;
  logic        full;
  logic        vote_ok, vote_match, vote_hit;
  always_comb begin
    case (tgt_q)
      TgtFirst: begin key = it_q.first_uid; kst = it_q.header_byte[2];
        kver = it_q.first_version; end
      TgtSecond: begin key = it_q.second_uid; kst = it_q.header_byte[3];
        kver = it_q.second_version; end
      default: begin key = cfg_i.own_uid; kst = dl_q; kver = self_ver_q; end
    endcase
  end
  assign diff = kver - rdata[23:16];
  assign full = (total_q >= CntW'(TableDepth));

  assign vote_ok = (it_q.opinion_byte <= 8'd1);
  assign vote_match = (it_q.opinion_byte[0] == opin_q);
  assign vote_hit = (agree_q >= cfg_i.agree_limit) || (agree_q + 8'd1 >= cfg_i.agree_limit);

  always_comb begin
    we = 1'b0;
    addr = idx_q[IdxW-1:0];
    wdata = {kst, kver, key};
    case (state_q)
      S_SCAN: addr = idx_q[IdxW-1:0];
      S_UPD: begin
        we = 1'b1;
        addr = idx_q[IdxW-1:0];
        if (tgt_q == TgtSelf || tgt_q == TgtSelfPost) begin
          wdata = {dl_q, self_ver_q, cfg_i.own_uid};
        end
      end
      S_B1: addr = cur_q;
      S_B1W: addr = cur_q + IdxW'(1);
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; total_q <= '0; self_ver_q <= '0; agree_q <= '0;
      opin_q <= 1'b0; dl_q <= 1'b0; dg_q <= 1'b0; cur_q <= '0; sent_q <= '0;
      rv_q <= 1'b0; tgt_q <= TgtSelf; idx_q <= '0; merge_q <= 1'b0;
      it_q <= '0; res_q <= '0;
    end else begin
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          it_q <= item_i;
          res_q.out_header <= '0;
          res_q.out_first_uid <= '0; res_q.out_first_version <= '0;
          res_q.out_second_uid <= '0; res_q.out_second_version <= '0;
          case (item_i.op)
            OpStart: begin
              total_q <= '0; self_ver_q <= '0; cur_q <= '0; sent_q <= '0;
              agree_q <= '0; dl_q <= 1'b0; dg_q <= 1'b0;
              opin_q <= item_i.opinion_byte[0];
              tgt_q <= TgtSelf; idx_q <= '0;
              state_q <= S_UPD;  // append own record at index 0
            end
            OpRecv: state_q <= S_VOTE;
            OpBuild: begin
              if (total_q == '0) begin
                sent_q <= '0; state_q <= S_OUT;
              end else begin
                if (CntW'(cur_q) >= total_q) cur_q <= '0;
                state_q <= S_B1;
              end
            end
            default: begin
              if (sent_q != '0) begin
                if (CntW'(cur_q) + CntW'(sent_q) >= total_q) cur_q <= '0;
                else cur_q <= cur_q + IdxW'(sent_q);
              end
              state_q <= S_OUT;
            end
          endcase
        end
        S_VOTE: begin
          merge_q <= (it_q.marker_byte == FloodMark) && (it_q.header_byte[1:0] != 2'd3);
          tgt_q <= TgtSelf;
          idx_q <= '0;
          // own record needs a refresh when the opinion flips or done gets set
          state_q <= (vote_ok && (!vote_match || (vote_hit && !dl_q))) ? S_SCAN : S_NEXT;
          if (vote_ok) begin
            if (vote_match) begin
              if (vote_hit) begin
                agree_q <= cfg_i.agree_limit;
                if (!dl_q) dl_q <= 1'b1;
              end else begin
                agree_q <= agree_q + 8'd1;
              end
            end else begin
              opin_q <= it_q.opinion_byte[0]; agree_q <= '0; dl_q <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (idx_q >= total_q) begin
            // not found: append when there is room
            if (tgt_q == TgtSelf || tgt_q == TgtSelfPost || key != cfg_i.own_uid) begin
              if (!full) state_q <= S_UPD;
              else state_q <= S_NEXT;
            end else state_q <= S_NEXT;
          end else if ((tgt_q == TgtFirst || tgt_q == TgtSecond) && key == cfg_i.own_uid) begin
            state_q <= S_NEXT;
          end else state_q <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rdata[15:0] == key) begin
            if (tgt_q == TgtFirst || tgt_q == TgtSecond) begin
              state_q <= (diff != 8'd0 && !diff[7]) ? S_UPD : S_NEXT;
            end else if (rdata[24] != dl_q) begin
              self_ver_q <= self_ver_q + 8'd1;
              state_q <= S_UPD;
            end else state_q <= S_NEXT;
          end else begin
            idx_q <= idx_q + CntW'(1);
            state_q <= S_SCAN;
          end
        end
        S_UPD: begin
          if (idx_q >= total_q) total_q <= total_q + CntW'(1);
          state_q <= (it_q.op == OpStart) ? S_OUT : S_NEXT;
        end
        S_NEXT: begin
          // advance to the next scan job of a receive
          idx_q <= '0;
          if (!merge_q || tgt_q == TgtSelfPost) begin
            state_q <= (merge_q && tgt_q == TgtSelfPost) ? S_GCHK : S_OUT;
          end else if (tgt_q == TgtSelf && it_q.header_byte[1:0] >= 2'd1) begin
            tgt_q <= TgtFirst; state_q <= S_SCAN;
          end else if (tgt_q == TgtFirst && it_q.header_byte[1:0] == 2'd2) begin
            tgt_q <= TgtSecond; state_q <= S_SCAN;
          end else begin
            tgt_q <= TgtSelfPost; state_q <= S_SCAN;
          end
        end
        S_GCHK: begin
          if (dg_q || !dl_q || total_q < CntW'(cfg_i.detection_count)) state_q <= S_OUT;
          else if (idx_q >= CntW'(cfg_i.detection_count)) begin
            dg_q <= 1'b1; state_q <= S_OUT;
          end else state_q <= S_GWAIT;
        end
        S_GWAIT: state_q <= S_GTEST;
        S_GTEST: begin
          if (!rdata[24]) state_q <= S_OUT;
          else begin
            idx_q <= idx_q + CntW'(1); state_q <= S_GCHK;
          end
        end
        S_B1: state_q <= S_B1W;
        S_B1W: begin
          res_q.out_first_uid <= rdata[15:0];
          res_q.out_first_version <= rdata[23:16];
          res_q.out_header <= {1'b0, rdata[24], 2'd1};
          sent_q <= 2'd1;
          if (CntW'(cur_q) + CntW'(1) < total_q) state_q <= S_B2W;
          else state_q <= S_OUT;
        end
        S_B2W: begin
          res_q.out_second_uid <= rdata[15:0];
          res_q.out_second_version <= rdata[23:16];
          res_q.out_header[3] <= rdata[24];
          res_q.out_header[1:0] <= 2'd2;
          sent_q <= 2'd2;
          state_q <= S_OUT;
        end
        S_OUT: begin
          res_q.out_opinion <= opin_q;
          res_q.local_complete <= dl_q;
          res_q.meta_complete <= dg_q;
          res_q.known_count <= 8'(total_q);
          rv_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/versioned_gossip_table_with_voting.sv -----
// Versioned gossip table with voting: top level.
// Start appends the own record, build reads up to two records and transmit done
// moves the read cursor; a receive runs up to 4 table scans (vote refresh, two
// records, own record) plus a state check over detection_count entries.
// One item at a time; a result waits in an output register.
// rst_ni clears control state; the table contents stay undefined until written.
`timescale 1ns / 1ps
module versioned_gossip_table_with_voting import vgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op, opinion_byte, header_byte, marker_byte, first_uid, first_version,
  // second_uid, second_version, zero pad
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_opinion, out_header, out_first_uid, out_first_version, out_second_uid,
  // out_second_version, local_complete, meta_complete, known_count, zero pad
  output logic [63:0] m_axis_tdata
);
  cfg_t    cfg;
  item_t   item;
  result_t res;

  vgt_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .cfg_o(cfg)
  );

  assign item.op             = s_axis_tdata[1:0];
  assign item.opinion_byte   = s_axis_tdata[9:2];
  assign item.header_byte    = s_axis_tdata[17:10];
  assign item.marker_byte    = s_axis_tdata[25:18];
  assign item.first_uid      = s_axis_tdata[41:26];
  assign item.first_version  = s_axis_tdata[49:42];
  assign item.second_uid     = s_axis_tdata[65:50];
  assign item.second_version = s_axis_tdata[73:66];

  vgt_seq u_seq (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .item_i(item), .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.known_count, res.meta_complete, res.local_complete,
                         res.out_second_version, res.out_second_uid,
                         res.out_first_version, res.out_first_uid,
                         res.out_header, res.out_opinion};
endmodule
